### hw/rtl/taabb_pkg.sv
package taabb_pkg;

    localparam int COORD_W    = 32;
    localparam int NUM_REGS   = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int NUM_STAGES = 5;
    localparam int NUM_AXES   = 3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [CFG_DATA_W-1:0]     cfg_word_t;
    typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

    localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
    localparam coord_t COORD_MIN = 32'sh8000_0000;

    // register map
    localparam cfg_idx_t REG_ROW_X_AB = 3'd0;
    localparam cfg_idx_t REG_ROW_X_CT = 3'd1;
    localparam cfg_idx_t REG_ROW_Y_AB = 3'd2;
    localparam cfg_idx_t REG_ROW_Y_CT = 3'd3;
    localparam cfg_idx_t REG_ROW_Z_AB = 3'd4;
    localparam cfg_idx_t REG_ROW_Z_CT = 3'd5;

    // per-stage advance enables, one bit per pipeline stage
    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } stage_en_t;

endpackage

### hw/rtl/taabb_if.sv
interface taabb_box_if;
    logic            valid;
    logic            ready;
    taabb_pkg::coord_t in_min_x;
    taabb_pkg::coord_t in_min_y;
    taabb_pkg::coord_t in_min_z;
    taabb_pkg::coord_t in_max_x;
    taabb_pkg::coord_t in_max_y;
    taabb_pkg::coord_t in_max_z;

    modport source (
        output valid, in_min_x, in_min_y, in_min_z, in_max_x, in_max_y, in_max_z,
        input  ready
    );
    modport sink (
        input  valid, in_min_x, in_min_y, in_min_z, in_max_x, in_max_y, in_max_z,
        output ready
    );
endinterface

interface taabb_res_if;
    logic            valid;
    logic            ready;
    taabb_pkg::coord_t out_min_x;
    taabb_pkg::coord_t out_min_y;
    taabb_pkg::coord_t out_min_z;
    taabb_pkg::coord_t out_max_x;
    taabb_pkg::coord_t out_max_y;
    taabb_pkg::coord_t out_max_z;
    taabb_pkg::coord_t mid_x;
    taabb_pkg::coord_t mid_y;
    taabb_pkg::coord_t mid_z;
    logic            saturated;

    modport source (
        output valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
               mid_x, mid_y, mid_z, saturated,
        input  ready
    );
    modport sink (
        input  valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
               mid_x, mid_y, mid_z, saturated,
        output ready
    );
endinterface

interface taabb_cfg_if;
    logic                   valid;
    logic                   ready;
    taabb_pkg::cfg_idx_t    idx;
    taabb_pkg::cfg_word_t   data;

    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface

### hw/rtl/taabb_axis.sv
// One output axis. Since floor and clamp are monotonic, the extreme corner
// is found per term: min/max of coef*lo and coef*hi, summed.
module taabb_axis #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  taabb_pkg::stage_en_t adv,
    input  taabb_pkg::coord_t    lo   [3],
    input  taabb_pkg::coord_t    hi   [3],
    input  taabb_pkg::coord_t    coef [3],
    input  taabb_pkg::coord_t    trans,
    output taabb_pkg::coord_t    mn,
    output taabb_pkg::coord_t    mx,
    output taabb_pkg::coord_t    mid,
    output logic                 sat
);

    typedef logic signed [2*taabb_pkg::COORD_W-1:0]   prod_t;
    typedef logic signed [2*taabb_pkg::COORD_W+1:0]   sum_t;
    typedef logic signed [2*taabb_pkg::COORD_W+2:0]   wide_t;
    typedef logic signed [taabb_pkg::COORD_W:0]       half_t;

    prod_t plo_reg [3];
    prod_t phi_reg [3];
    prod_t pmin_reg [3];
    prod_t pmax_reg [3];
    sum_t  smin_reg;
    sum_t  smax_reg;
    taabb_pkg::coord_t mn4_reg, mx4_reg;
    logic  sat4_reg;
    taabb_pkg::coord_t mn_reg, mx_reg, mid_reg;
    logic  sat_reg;

    wide_t rmin, rmax;
    taabb_pkg::coord_t mn4_next, mx4_next;
    logic  sat4_next;
    half_t span, mid_next;

    // stage 1: exact products
    always_ff @(posedge clk)
    begin
        if (adv.en[0])
        begin
            for (int k = 0; k < 3; k++)
            begin
                plo_reg[k] <= coef[k] * lo[k];
                phi_reg[k] <= coef[k] * hi[k];
            end
        end
    end

    // stage 2: per-term extremes
    always_ff @(posedge clk)
    begin
        if (adv.en[1])
        begin
            for (int k = 0; k < 3; k++)
            begin
                pmin_reg[k] <= (plo_reg[k] < phi_reg[k]) ? plo_reg[k] : phi_reg[k];
                pmax_reg[k] <= (plo_reg[k] < phi_reg[k]) ? phi_reg[k] : plo_reg[k];
            end
        end
    end

    // stage 3: sums
    always_ff @(posedge clk)
    begin
        if (adv.en[2])
        begin
            smin_reg <= sum_t'(pmin_reg[0]) + sum_t'(pmin_reg[1]) + sum_t'(pmin_reg[2]);
            smax_reg <= sum_t'(pmax_reg[0]) + sum_t'(pmax_reg[1]) + sum_t'(pmax_reg[2]);
        end
    end

    // stage 4: floor back to fixed point, translate, clamp
    always_comb
    begin
        rmin = wide_t'(smin_reg >>> FRAC_BITS) + wide_t'(trans);
        rmax = wide_t'(smax_reg >>> FRAC_BITS) + wide_t'(trans);
        sat4_next = 1'b0;
        if (rmin < wide_t'(taabb_pkg::COORD_MIN))
        begin
            mn4_next  = taabb_pkg::COORD_MIN;
            sat4_next = 1'b1;
        end
        else if (rmin > wide_t'(taabb_pkg::COORD_MAX))
        begin
            mn4_next  = taabb_pkg::COORD_MAX;
            sat4_next = 1'b1;
        end
        else
        begin
            mn4_next = rmin[taabb_pkg::COORD_W-1:0];
        end
        if (rmax > wide_t'(taabb_pkg::COORD_MAX))
        begin
            mx4_next  = taabb_pkg::COORD_MAX;
            sat4_next = 1'b1;
        end
        else if (rmax < wide_t'(taabb_pkg::COORD_MIN))
        begin
            mx4_next  = taabb_pkg::COORD_MIN;
            sat4_next = 1'b1;
        end
        else
        begin
            mx4_next = rmax[taabb_pkg::COORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.en[3])
        begin
            mn4_reg  <= mn4_next;
            mx4_reg  <= mx4_next;
            sat4_reg <= sat4_next;
        end
    end

    // stage 5: centre, span is never negative
    always_comb
    begin
        span     = half_t'(mx4_reg) - half_t'(mn4_reg);
        mid_next = half_t'(mn4_reg) + (span >>> 1);
    end

    always_ff @(posedge clk)
    begin
        if (adv.en[4])
        begin
            mn_reg  <= mn4_reg;
            mx_reg  <= mx4_reg;
            mid_reg <= mid_next[taabb_pkg::COORD_W-1:0];
            sat_reg <= sat4_reg;
        end
    end

    assign mn  = mn_reg;
    assign mx  = mx_reg;
    assign mid = mid_reg;
    assign sat = sat_reg;

endmodule

### hw/rtl/transform_aabb_unit.sv
// Affine transform of an axis-aligned box, five-stage pipeline.
// Throughput: one box per cycle while the output is not stalled, set by the 18
// parallel 32x32 multipliers of stage 1.
// Stalls back up stage by stage; empty stages still fill while the output waits.
// Reset (rst_n, async, active low) empties the pipeline and loads the identity matrix.
module transform_aabb_unit #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    taabb_box_if.sink          box_in,
    taabb_res_if.source        box_out,
    taabb_cfg_if.sink          cfg
);

    localparam taabb_pkg::cfg_word_t ONE = taabb_pkg::cfg_word_t'(1) << COORD_FRAC_BITS;

    taabb_pkg::cfg_word_t        cfg_reg [taabb_pkg::NUM_REGS];
    logic [taabb_pkg::NUM_STAGES-1:0] v_reg;
    taabb_pkg::stage_en_t        adv;

    taabb_pkg::coord_t lo_in [3];
    taabb_pkg::coord_t hi_in [3];
    taabb_pkg::coord_t mn [3];
    taabb_pkg::coord_t mx [3];
    taabb_pkg::coord_t mid [3];
    logic [taabb_pkg::NUM_AXES-1:0] sat;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[taabb_pkg::REG_ROW_X_AB] <= ONE << 32;
            cfg_reg[taabb_pkg::REG_ROW_X_CT] <= '0;
            cfg_reg[taabb_pkg::REG_ROW_Y_AB] <= ONE;
            cfg_reg[taabb_pkg::REG_ROW_Y_CT] <= '0;
            cfg_reg[taabb_pkg::REG_ROW_Z_AB] <= '0;
            cfg_reg[taabb_pkg::REG_ROW_Z_CT] <= ONE << 32;
        end
        else if (cfg.valid && cfg.ready && (int'(cfg.idx) < taabb_pkg::NUM_REGS))
        begin
            cfg_reg[cfg.idx] <= cfg.data;
        end
    end

    // pipeline control: a stage moves when it is empty or the next one moves
    always_comb
    begin
        adv.en[taabb_pkg::NUM_STAGES-1] = !v_reg[taabb_pkg::NUM_STAGES-1] || box_out.ready;
        for (int i = taabb_pkg::NUM_STAGES - 2; i >= 0; i--)
        begin
            adv.en[i] = !v_reg[i] || adv.en[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv.en[0])
            begin
                v_reg[0] <= box_in.valid;
            end
            for (int i = 1; i < taabb_pkg::NUM_STAGES; i++)
            begin
                if (adv.en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign box_in.ready  = adv.en[0];
    assign box_out.valid = v_reg[taabb_pkg::NUM_STAGES-1];

    assign lo_in[0] = box_in.in_min_x;
    assign lo_in[1] = box_in.in_min_y;
    assign lo_in[2] = box_in.in_min_z;
    assign hi_in[0] = box_in.in_max_x;
    assign hi_in[1] = box_in.in_max_y;
    assign hi_in[2] = box_in.in_max_z;

    for (genvar a = 0; a < taabb_pkg::NUM_AXES; a++)
    begin : g_axis
        taabb_pkg::coord_t coef [3];
        taabb_pkg::coord_t trans;

        assign coef[0] = cfg_reg[2*a][63:32];
        assign coef[1] = cfg_reg[2*a][31:0];
        assign coef[2] = cfg_reg[2*a+1][63:32];
        assign trans   = cfg_reg[2*a+1][31:0];

        taabb_axis #(
            .FRAC_BITS (COORD_FRAC_BITS)
        ) u_axis (
            .clk   (clk),
            .adv   (adv),
            .lo    (lo_in),
            .hi    (hi_in),
            .coef  (coef),
            .trans (trans),
            .mn    (mn[a]),
            .mx    (mx[a]),
            .mid   (mid[a]),
            .sat   (sat[a])
        );
    end

    assign box_out.out_min_x = mn[0];
    assign box_out.out_min_y = mn[1];
    assign box_out.out_min_z = mn[2];
    assign box_out.out_max_x = mx[0];
    assign box_out.out_max_y = mx[1];
    assign box_out.out_max_z = mx[2];
    assign box_out.mid_x     = mid[0];
    assign box_out.mid_y     = mid[1];
    assign box_out.mid_z     = mid[2];
    assign box_out.saturated = |sat;

`ifndef SYNTHESIS
    // an output that is taken never blocks the input
    a_ready_through: assert property (@(posedge clk) disable iff (!rst_n)
        box_out.ready |-> box_in.ready)
        else $error("input stalled while output is being taken");

    // a full pipeline behind a stalled output must refuse new beats
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&v_reg) && !box_out.ready |-> !box_in.ready)
        else $error("beat accepted into a full stalled pipeline");

    // an accepted beat lands in stage 1
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        box_in.valid && box_in.ready |=> v_reg[0])
        else $error("accepted beat lost at stage 1");

    // an item moving out of stage 1 lands in stage 2
    a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
        adv.en[1] && v_reg[0] |=> v_reg[1])
        else $error("item lost between stage 1 and stage 2");
`endif

endmodule
